// ===== rtl/core/bspu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit packer package
// Field widths, command, mode and status codes, and the control and status
// structs shared by the bit packer modules.
// ---------------------------------------------------------------------------
package bspu_pkg;

   localparam int unsigned BUFFER_BYTES_DEF = 256;

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned ACTUAL_W = COUNT_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(32);

   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EXTRACT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET_RD  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CAP     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BIT_RD  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BYTE_RD = 3'd6;
   localparam logic [CMD_W-1:0] CMD_BYTE_WR = 3'd7;

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DUP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ILV    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COUNT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MODE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd5;

   // Control from the sequencer to the append bit source.
   typedef struct packed {
      logic load;
      logic step;
   } bspu_src_ctl_type;

   // Status from the append bit source.
   typedef struct packed {
      logic bit_val;
      logic last;
   } bspu_src_sts_type;

endpackage

// ===== rtl/core/bitstream_pack_unpack_buffer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitstream pack/unpack buffer
// MSB-first bit packer over a byte store, with write and read pointers.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its one result shows
// on the rsp_ ports for a single cycle with rsp_strobe high; the receiver
// cannot stall it, so it must take every result in that cycle. Bits move one
// per cycle through the append bit source and the byte accumulator, and
// extracted bits shift one per cycle into the data register; the store has
// one read and one write port. Append runs evaluate, byte load, one bit step
// per stream bit (the bit count, doubled in both complement modes) and flush;
// extract runs evaluate and one step per extracted bit; bit read and byte
// read run evaluate and read; everything else, and every error, ends in
// evaluate. A new command may be started in the very cycle the previous
// result is on the ports.
// ---------------------------------------------------------------------------
module bitstream_pack_unpack_buffer_core #(
   parameter int unsigned BUFFER_BYTES = bspu_pkg::BUFFER_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bspu_pkg::CMD_W-1:0]    req_command,
   input  logic [bspu_pkg::VALUE_W-1:0]  req_value,
   input  logic [bspu_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic [bspu_pkg::MODE_W-1:0]   req_mode,
   input  logic [bspu_pkg::POS_W-1:0]    req_position,
   input  logic [bspu_pkg::BYTE_W-1:0]   req_byte_value,
   output logic                          rsp_strobe,
   output logic [bspu_pkg::VALUE_W-1:0]  rsp_data,
   output logic [bspu_pkg::STATUS_W-1:0] rsp_status,
   output logic [bspu_pkg::POS_W-1:0]    rsp_write_position,
   output logic [bspu_pkg::POS_W-1:0]    rsp_read_position
);
   import bspu_pkg::*;

   // Pointers count bits; the byte address is the pointer without its low
   // three bits. Compares run on a width that holds a pointer or a position
   // plus the longest stream.
   localparam int unsigned TOTAL_BITS = BUFFER_BYTES * 8;
   localparam int unsigned PTR_W      = $clog2(TOTAL_BITS);
   localparam int unsigned AW         = PTR_W - 3;
   localparam int unsigned CMP_W      = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EVAL      = 3'd1;
   localparam logic [2:0] S_APP_LOAD  = 3'd2;
   localparam logic [2:0] S_APP_BIT   = 3'd3;
   localparam logic [2:0] S_APP_FLUSH = 3'd4;
   localparam logic [2:0] S_EXT       = 3'd5;
   localparam logic [2:0] S_READ      = 3'd6;

   logic [2:0]          state_ff,  state_in;
   logic [PTR_W-1:0]    wp_ff,     wp_in;
   logic [PTR_W-1:0]    rp_ff,     rp_in;
   logic                flag_ff,   flag_in;
   logic                strobe_ff, strobe_in;

   logic [CMD_W-1:0]    cmd_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [BYTE_W-1:0]   bval_ff;
   logic [BYTE_W-1:0]   acc_ff,    acc_in;
   logic [VALUE_W-1:0]  dsh_ff,    dsh_in;
   logic [COUNT_W-1:0]  left_ff,   left_in;
   logic [VALUE_W-1:0]  data_ff,   data_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0]       rd_addr_ff;

   logic                accept;
   logic [CMP_W-1:0]    pos_ext, wp_ext, rp_ext, touched, app_end, ext_end;
   logic [ACTUAL_W-1:0] actual;
   logic                cnt_zero, cnt_big, mode_bad;
   logic [STATUS_W-1:0] ev_status;
   logic [2:0]          ev_next;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [BYTE_W-1:0]   wr_data, mem_q, byte_v, acc_or;
   logic [PTR_W-1:0]    wp_inc;
   logic [ACTUAL_W-1:0] rp_step;
   logic                ext_bit, ext_last, rd_bit;

   bspu_src_ctl_type    src_ctl;
   bspu_src_sts_type    src_sts;

   bspu_store #(
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   bspu_bitsrc u_bitsrc (
      .clock (clock),
      .reset (reset),
      .ctl   (src_ctl),
      .value (req_value),
      .count (req_bit_count),
      .mode  (req_mode),
      .sts   (src_sts)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign pos_ext = CMP_W'(pos_ff);
   assign wp_ext  = CMP_W'(wp_ff);
   assign rp_ext  = CMP_W'(rp_ff);
   assign touched = (wp_ext + CMP_W'(7)) >> 3;
   assign actual  = (mode_ff != MODE_NORMAL) ? {cnt_ff, 1'b0} : {1'b0, cnt_ff};
   assign app_end = wp_ext + CMP_W'(actual);
   assign ext_end = rp_ext + CMP_W'(actual);

   assign cnt_zero = (cnt_ff == '0);
   assign cnt_big  = (cnt_ff > COUNT_MAX);
   assign mode_bad = (mode_ff == MODE_BAD);

   // Byte zero reads as zero until something has been written to it.
   assign byte_v = (rd_addr_ff == '0 && !flag_ff) ? '0 : mem_q;

   assign ext_bit  = byte_v[~rp_ff[2:0]];
   assign ext_last = (left_ff == COUNT_W'(1));
   assign rd_bit   = byte_v[~pos_ff[2:0]];

   assign wp_inc = wp_ff + PTR_W'(1);
   assign acc_or = src_sts.bit_val ? (acc_ff | (8'h80 >> wp_ff[2:0])) : acc_ff;

   // Extract moves one bit, or two in the interleaved mode; the duplicated
   // mode skips the whole complement copy after the last bit.
   always_comb begin
      rp_step = (mode_ff == MODE_ILV) ? ACTUAL_W'(2) : ACTUAL_W'(1);
      if (ext_last && mode_ff == MODE_DUP) begin
         rp_step = rp_step + ACTUAL_W'(cnt_ff);
      end
   end

   // Checks of a command in the order that decides its status.
   always_comb begin
      ev_status = ST_OK;
      ev_next   = S_IDLE;
      unique case (cmd_ff)
         CMD_APPEND: begin
            priority if (cnt_zero) begin
               ev_status = ST_OK;
            end else if (cnt_big) begin
               ev_status = ST_COUNT;
            end else if (mode_bad) begin
               ev_status = ST_MODE;
            end else if (app_end >= CMP_W'(TOTAL_BITS)) begin
               ev_status = ST_FULL;
            end else begin
               ev_next = S_APP_LOAD;
            end
         end
         CMD_EXTRACT: begin
            // Availability is tested before the mode, with the count doubled in every mode but normal.
            priority if (cnt_zero) begin
               ev_status = ST_OK;
            end else if (cnt_big) begin
               ev_status = ST_COUNT;
            end else if (ext_end > wp_ext) begin
               ev_status = ST_SHORT;
            end else if (mode_bad) begin
               ev_status = ST_MODE;
            end else begin
               ev_next = S_EXT;
            end
         end
         CMD_SET_RD: begin
            if (pos_ff != '0 && pos_ext >= wp_ext) begin
               ev_status = ST_RANGE;
            end
         end
         CMD_CLEAR: begin
            ev_status = ST_OK;
         end
         CMD_CAP: begin
            if (pos_ext > wp_ext) begin
               ev_status = ST_RANGE;
            end
         end
         CMD_BIT_RD: begin
            if (pos_ext >= wp_ext) begin
               ev_status = ST_RANGE;
            end else begin
               ev_next = S_READ;
            end
         end
         CMD_BYTE_RD: begin
            if (pos_ext >= touched) begin
               ev_status = ST_RANGE;
            end else begin
               ev_next = S_READ;
            end
         end
         CMD_BYTE_WR: begin
            if (pos_ext >= touched) begin
               ev_status = ST_RANGE;
            end
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      flag_in   = flag_ff;
      strobe_in = 1'b0;
      acc_in    = acc_ff;
      dsh_in    = dsh_ff;
      left_in   = left_ff;
      data_in   = data_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = wp_ff[PTR_W-1:3];
      wr_data   = acc_ff;
      src_ctl   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               src_ctl.load = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            dsh_in   = '0;
            left_in  = cnt_ff;
            state_in = ev_next;
            if (ev_next == S_IDLE) begin
               strobe_in = 1'b1;
               status_in = ev_status;
               data_in   = '0;
               if (ev_status == ST_OK) begin
                  unique case (cmd_ff)
                     CMD_SET_RD: begin
                        rp_in = pos_ext[PTR_W-1:0];
                     end
                     CMD_CLEAR: begin
                        wp_in   = '0;
                        rp_in   = '0;
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = '0;
                     end
                     CMD_CAP: begin
                        // Only the pointer moves; stale bits in its byte stay.
                        wp_in = pos_ext[PTR_W-1:0];
                     end
                     CMD_BYTE_WR: begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ext[AW-1:0];
                        wr_data = bval_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_APP_LOAD: begin
            acc_in   = byte_v;
            state_in = S_APP_BIT;
         end
         S_APP_BIT: begin
            src_ctl.step = 1'b1;
            wp_in        = wp_inc;
            if (wp_inc[2:0] == 3'd0) begin
               // The byte is full: store it and start the next one at zero.
               wr_en   = 1'b1;
               wr_data = acc_or;
               acc_in  = '0;
            end else begin
               acc_in = acc_or;
            end
            if (src_sts.last) begin
               state_in = S_APP_FLUSH;
            end
         end
         S_APP_FLUSH: begin
            // Stores the partial byte, or the zeroed next byte.
            wr_en     = 1'b1;
            strobe_in = 1'b1;
            status_in = ST_OK;
            data_in   = '0;
            state_in  = S_IDLE;
         end
         S_EXT: begin
            dsh_in  = {dsh_ff[VALUE_W-2:0], ext_bit};
            left_in = left_ff - COUNT_W'(1);
            rp_in   = rp_ff + PTR_W'(rp_step);
            if (ext_last) begin
               strobe_in = 1'b1;
               status_in = ST_OK;
               data_in   = dsh_in;
               state_in  = S_IDLE;
            end
         end
         S_READ: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            data_in   = (cmd_ff == CMD_BIT_RD) ? VALUE_W'(rd_bit) : VALUE_W'(byte_v);
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en && wr_addr == '0) begin
         flag_in = 1'b1;
      end
   end

   // Read address: the byte the next cycle works on. During extract it
   // follows the next read pointer so one bit is taken every cycle.
   always_comb begin
      rd_addr = wp_ff[PTR_W-1:3];
      if (state_ff == S_EVAL) begin
         unique case (cmd_ff)
            CMD_EXTRACT: rd_addr = rp_ff[PTR_W-1:3];
            CMD_BIT_RD:  rd_addr = pos_ext[AW+2:3];
            CMD_BYTE_RD: rd_addr = pos_ext[AW-1:0];
            default:     rd_addr = wp_ff[PTR_W-1:3];
         endcase
      end else if (state_ff == S_EXT) begin
         rd_addr = rp_in[PTR_W-1:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wp_ff     <= '0;
         rp_ff     <= '0;
         flag_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         flag_ff   <= flag_in;
         strobe_ff <= strobe_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         cnt_ff  <= req_bit_count;
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         bval_ff <= req_byte_value;
      end
      acc_ff     <= acc_in;
      dsh_ff     <= dsh_in;
      data_ff    <= data_in;
      status_ff  <= status_in;
      rd_addr_ff <= rd_addr;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_data           = data_ff;
   assign rsp_status         = status_ff;
   assign rsp_write_position = wp_ext[POS_W-1:0];
   assign rsp_read_position  = rp_ext[POS_W-1:0];

endmodule

// ===== rtl/core/bspu_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit packer byte store
// Single write port, single read port byte memory with registered read data.
// ---------------------------------------------------------------------------
module bspu_store #(
   parameter int unsigned DEPTH = bspu_pkg::BUFFER_BYTES_DEF,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bspu_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [bspu_pkg::BYTE_W-1:0] rd_data
);
   import bspu_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bspu_bitsrc.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit packer append bit source
// Emits the append bit stream one bit per step, most significant bit first,
// with the complement copy or the interleaved inverse bits of the mode.
// ---------------------------------------------------------------------------
module bspu_bitsrc (
   input  logic                         clock,
   input  logic                         reset,
   input  bspu_pkg::bspu_src_ctl_type   ctl,
   input  logic [bspu_pkg::VALUE_W-1:0] value,
   input  logic [bspu_pkg::COUNT_W-1:0] count,
   input  logic [bspu_pkg::MODE_W-1:0]  mode,
   output bspu_pkg::bspu_src_sts_type   sts
);
   import bspu_pkg::*;

   localparam int unsigned IDX_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0]  val_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [IDX_W-1:0]    idx_ff,   idx_in;
   logic                inv_ff,   inv_in;
   logic                pass2_ff, pass2_in;
   logic [ACTUAL_W-1:0] left_ff,  left_in;

   always_comb begin
      idx_in   = idx_ff;
      inv_in   = inv_ff;
      pass2_in = pass2_ff;
      left_in  = left_ff;
      if (ctl.load) begin
         idx_in   = count[IDX_W-1:0] - IDX_W'(1);
         inv_in   = 1'b0;
         pass2_in = 1'b0;
         left_in  = (mode != MODE_NORMAL) ? {count, 1'b0} : {1'b0, count};
      end else if (ctl.step) begin
         left_in = left_ff - ACTUAL_W'(1);
         unique case (mode_ff)
            MODE_ILV: begin
               // Each bit goes out twice, the second time inverted.
               inv_in = !inv_ff;
               if (inv_ff) begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
            MODE_DUP: begin
               // After the last value bit the whole value runs again inverted.
               if (idx_ff == '0 && !pass2_ff) begin
                  pass2_in = 1'b1;
                  inv_in   = 1'b1;
                  idx_in   = cnt_ff[IDX_W-1:0] - IDX_W'(1);
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
            default: begin
               idx_in = idx_ff - IDX_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         val_ff  <= value;
         cnt_ff  <= count;
         mode_ff <= mode;
      end
      idx_ff   <= idx_in;
      inv_ff   <= inv_in;
      pass2_ff <= pass2_in;
   end

   assign sts.bit_val = val_ff[idx_ff] ^ inv_ff;
   assign sts.last    = (left_ff == ACTUAL_W'(1));

endmodule

// ===== rtl/core/bspu_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit packer port checker
// Checks on the command and result ports of the bit packer over time.
// ---------------------------------------------------------------------------
module bspu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [bspu_pkg::VALUE_W-1:0]  rsp_data,
   input logic [bspu_pkg::STATUS_W-1:0] rsp_status
);
   import bspu_pkg::*;

   // A taken command keeps the block busy until its result.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer not followed by busy");

   // The block leaves busy only by giving a result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a result transfer");

   // Results are single cycle pulses.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Errors carry a known code and no data.
   a_error_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_data == '0 && rsp_status <= ST_RANGE))
      else $error("error result with data or unknown status");

endmodule

bind bitstream_pack_unpack_buffer_core bspu_checker u_bspu_checker (.*);
